/* rtl/nmea_sentence_parser_top_assert.svh */
// Assertion macros for the sentence parser.
`ifndef NMEA_SENTENCE_PARSER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_PARSER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NSP_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define NSP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define NSP_ASSERT_IMPL(label, clk, rst, prop)
`define NSP_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/nsp_pkg.sv */
// ----------------------------------------------------------------------------
// nsp_pkg
// Types and constants shared by the sentence parser modules.
// ----------------------------------------------------------------------------
package nsp_pkg;
   localparam int MAX_LINE = 128;
   localparam int LEN_W = $clog2(MAX_LINE);
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_PULSE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [2:0] EV_REJECT  = 3'd0;
   localparam logic [2:0] EV_RMC     = 3'd1;
   localparam logic [2:0] EV_GGA     = 3'd2;
   localparam logic [2:0] EV_GSV     = 3'd3;
   localparam logic [2:0] EV_PULSE   = 3'd4;
   localparam logic [2:0] EV_TIMEOUT = 3'd5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam int QDEPTH = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic        has_fix;
      logic [23:0] utc_time_bcd;
      logic [23:0] date_bcd;
      logic [7:0]  sats_used;
      logic [15:0] hdop_centi;
      logic [7:0]  sats_visible;
      logic        pulse_valid;
      logic [31:0] pulse_count;
   } rsp_type;

   // Action handed from the front end to the back end.
   typedef struct packed {
      logic       is_eol;
      logic       is_char;
      logic       is_pulse;
      logic       is_tick;
      logic [LEN_W-1:0] pos;
      logic [7:0] data;
   } op_type;

   function automatic logic [5:0] tag_mismatch(input logic [2:0] p, input logic [7:0] c);
      logic [7:0] t [0:5];
      logic [5:0] m;
      begin
         t[0] = "$"; t[1] = "G"; t[2] = "P"; t[3] = "R"; t[4] = "M"; t[5] = "C";
         m = '0;
         for (int k = 0; k < 6; k++) begin
            logic [7:0] e;
            e = t[p];
            if (p == 3'd2) e = (k % 2 == 1) ? "N" : "P";
            if (p == 3'd3) e = (k < 2) ? "R" : "G";
            if (p == 3'd4) e = (k < 2) ? "M" : ((k < 4) ? "G" : "S");
            if (p == 3'd5) e = (k < 2) ? "C" : ((k < 4) ? "A" : "V");
            if (e != c) m[k] = 1'b1;
         end
         return m;
      end
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction
endpackage

/* rtl/nsp_front.sv */
// ----------------------------------------------------------------------------
// nsp_front
// Accepts items, tracks line length, and queues at most one action per item.
// ----------------------------------------------------------------------------
module nsp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nsp_pkg::req_type   req_data,
   output logic               op_valid,
   input  logic               op_ready,
   output nsp_pkg::op_type    op_data
);
   nsp_pkg::op_type q_ff [nsp_pkg::QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic [nsp_pkg::LEN_W-1:0] len_ff, len_in;
   nsp_pkg::op_type op;
   logic push, pop, take;

   assign req_ready = (cnt_ff != 2'd2);
   assign take = req_valid && req_ready;
   assign op_valid = (cnt_ff != 2'd0);
   assign op_data = q_ff[rp_ff];
   assign pop = op_valid && op_ready;

   always_comb begin
      op = '0;
      op.data = req_data.data_byte;
      op.pos = len_ff;
      len_in = len_ff;
      unique case (req_data.kind)
         nsp_pkg::KIND_BYTE: begin
            if (req_data.data_byte == 8'h0A) begin
               op.is_eol = 1'b1;
               len_in = '0;
            end else if (req_data.data_byte != 8'h0D &&
                         len_ff != nsp_pkg::LEN_W'(nsp_pkg::MAX_LINE - 1)) begin
               op.is_char = 1'b1;
               len_in = len_ff + 1'b1;
            end
         end
         nsp_pkg::KIND_PULSE: op.is_pulse = 1'b1;
         nsp_pkg::KIND_TICK:  op.is_tick = 1'b1;
         default: ;
      endcase
      push = take && (op.is_eol || op.is_char || op.is_pulse || op.is_tick);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         len_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         if (take) len_ff <= len_in;
      end
      if (push) q_ff[wp_ff] <= op;
   end
endmodule

/* rtl/nsp_back.sv */
// ----------------------------------------------------------------------------
// nsp_back
// Field parsing, commit, pulse supervision and the result register.
// ----------------------------------------------------------------------------
module nsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       timeout,
   input  logic              op_valid,
   output logic              op_ready,
   input  nsp_pkg::op_type   op_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nsp_pkg::rsp_type  rsp_data
);
   logic dol_ff, dol_in, star_ff, star_in, frz_ff, frz_in, ds_ff, ds_in, hs_ff, hs_in;
   logic [5:0] tm_ff, tm_in, pf_ff, pf_in;
   logic [7:0] xs_ff, xs_in, rs_ff, rs_in;
   logic [4:0] fi_ff, fi_in;
   logic [6:0] ci_ff, ci_in;
   logic [1:0] hf_ff, hf_in;
   logic [23:0] pt_ff, pt_in, pd_ff, pd_in, ct_ff, ct_in, cd_ff, cd_in;
   logic pfx_ff, pfx_in, cfx_ff, cfx_in;
   logic [7:0] psu_ff, psu_in, piv_ff, piv_in, csu_ff, csu_in, civ_ff, civ_in;
   logic [15:0] ph_ff, ph_in, ch_ff, ch_in, ms_ff, ms_in;
   logic pv_ff, pv_in;
   logic [31:0] pc_ff, pc_in;
   logic emit;
   logic [2:0] ev;
   logic [19:0] hv;
   logic [3:0] dv, hx;
   logic hexok, proc, clr;
   logic [7:0] c;
   int item;
   nsp_pkg::rsp_type out_ff;
   logic ov_ff;

   assign op_ready = !ov_ff || rsp_ready;
   assign proc = op_valid && op_ready;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      dol_in = dol_ff; star_in = star_ff; frz_in = frz_ff; ds_in = ds_ff; hs_in = hs_ff;
      tm_in = tm_ff; pf_in = pf_ff; xs_in = xs_ff; rs_in = rs_ff; fi_in = fi_ff;
      ci_in = ci_ff; hf_in = hf_ff; pt_in = pt_ff; pd_in = pd_ff; pfx_in = pfx_ff;
      psu_in = psu_ff; piv_in = piv_ff; ph_in = ph_ff;
      ct_in = ct_ff; cd_in = cd_ff; cfx_in = cfx_ff; csu_in = csu_ff; civ_in = civ_ff;
      ch_in = ch_ff; ms_in = ms_ff; pv_in = pv_ff; pc_in = pc_ff;
      emit = 1'b0; ev = nsp_pkg::EV_REJECT; clr = 1'b0; item = -1;
      c = op_data.data;
      dv = c[3:0];
      hv = '0;
      hexok = 1'b1; hx = '0;
      if (nsp_pkg::is_digit(c)) hx = c[3:0];
      else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) hx = c[3:0] + 4'd9;
      else hexok = 1'b0;
      if (op_data.is_eol) begin
         emit = 1'b1; clr = 1'b1;
         if (dol_ff && star_ff && xs_ff == rs_ff && op_data.pos >= 6) begin
            if (|tm_ff[1:0]) ev = nsp_pkg::EV_RMC;
            else if (|tm_ff[3:2]) ev = nsp_pkg::EV_GGA;
            else if (|tm_ff[5:4]) ev = nsp_pkg::EV_GSV;
         end
         if (ev != nsp_pkg::EV_REJECT) begin
            if (pf_ff[0]) ct_in = pt_ff;
            if (pf_ff[1]) cfx_in = pfx_ff;
            if (pf_ff[2]) cd_in = pd_ff;
            if (pf_ff[3]) csu_in = psu_ff;
            if (pf_ff[4]) ch_in = ph_ff;
            if (pf_ff[5]) civ_in = piv_ff;
         end
      end else if (op_data.is_pulse) begin
         pv_in = 1'b1; ms_in = '0; pc_in = pc_ff + 32'd1;
         emit = 1'b1; ev = nsp_pkg::EV_PULSE;
      end else if (op_data.is_tick) begin
         if (pv_ff) begin
            if (ms_ff >= timeout) begin
               pv_in = 1'b0; emit = 1'b1; ev = nsp_pkg::EV_TIMEOUT;
            end else ms_in = ms_ff + 16'd1;
         end
      end else if (op_data.is_char && !frz_ff) begin
         if (op_data.pos == '0) dol_in = (c == "$");
         if (op_data.pos < 6) tm_in = tm_ff & ~nsp_pkg::tag_mismatch(op_data.pos[2:0], c);
         if (c == 8'h00) frz_in = 1'b1;
         else if (star_ff) begin
            if (!hs_ff) begin
               if (hexok) rs_in = {rs_ff[3:0], hx};
               else hs_in = 1'b1;
            end
         end else if (c == "*" && op_data.pos != '0) star_in = 1'b1;
         else begin
            if (op_data.pos != '0) xs_in = xs_ff ^ c;
            if (c == ",") begin
               if (fi_ff != 5'd31) fi_in = fi_ff + 5'd1;
               ci_in = '0; ds_in = 1'b0; hf_in = '0;
            end else begin
               if (|tm_ff[1:0]) begin
                  if (fi_ff == 5'd1) item = 0;
                  else if (fi_ff == 5'd2) item = 1;
                  else if (fi_ff == 5'd9) item = 2;
               end else if (|tm_ff[3:2]) begin
                  if (fi_ff == 5'd7) item = 3;
                  else if (fi_ff == 5'd8) item = 4;
               end else if (|tm_ff[5:4]) begin
                  if (fi_ff == 5'd3) item = 5;
               end
               if (item >= 0 && ci_ff == '0) pf_in[item] = 1'b1;
               case (item)
                  0, 2: if (!ds_ff) begin
                     if (nsp_pkg::is_digit(c)) begin
                        if (ci_ff < 7'd6) begin
                           if (item == 0) pt_in[(5 - ci_ff[2:0]) * 4 +: 4] = dv;
                           else pd_in[(5 - ci_ff[2:0]) * 4 +: 4] = dv;
                        end
                     end else ds_in = 1'b1;
                  end
                  1: if (ci_ff == '0) pfx_in = (c == "A");
                  3, 5: if (!ds_ff) begin
                     if (nsp_pkg::is_digit(c)) begin
                        if (item == 3) psu_in = 8'({psu_ff, 3'b0} + {psu_ff, 1'b0} + dv);
                        else piv_in = 8'({piv_ff, 3'b0} + {piv_ff, 1'b0} + dv);
                     end else ds_in = 1'b1;
                  end
                  4: if (!ds_ff) begin
                     if (nsp_pkg::is_digit(c)) begin
                        // Integer digits scale the value so far by ten and add d*100.
                        if (hf_ff == 2'd0)
                           hv = 20'(ph_ff) * 20'd10 + 20'(dv) * 20'd100;
                        else if (hf_ff == 2'd1) begin
                           hv = 20'(ph_ff) + 20'(dv) * 20'd10; hf_in = 2'd2;
                        end else if (hf_ff == 2'd2) begin
                           hv = 20'(ph_ff) + 20'(dv); hf_in = 2'd3;
                        end else hv = 20'(ph_ff);
                        ph_in = (hv > 20'd65535) ? 16'hFFFF : hv[15:0];
                     end else if (c == "." && hf_ff == 2'd0) hf_in = 2'd1;
                     else ds_in = 1'b1;
                  end
                  default: ;
               endcase
               if (ci_ff != 7'd127) ci_in = ci_ff + 7'd1;
            end
         end
      end
      if (clr) begin
         dol_in = 1'b0; star_in = 1'b0; frz_in = 1'b0; ds_in = 1'b0; hs_in = 1'b0;
         tm_in = 6'h3F; pf_in = '0; xs_in = '0; rs_in = '0; fi_in = '0; ci_in = '0;
         hf_in = '0; pt_in = '0; pd_in = '0; pfx_in = 1'b0; psu_in = '0; piv_in = '0;
         ph_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dol_ff <= 1'b0; star_ff <= 1'b0; frz_ff <= 1'b0; ds_ff <= 1'b0; hs_ff <= 1'b0;
         tm_ff <= 6'h3F; pf_ff <= '0; xs_ff <= '0; rs_ff <= '0; fi_ff <= '0; ci_ff <= '0;
         hf_ff <= '0; pt_ff <= '0; pd_ff <= '0; pfx_ff <= 1'b0; psu_ff <= '0;
         piv_ff <= '0; ph_ff <= '0; ct_ff <= '0; cd_ff <= '0; cfx_ff <= 1'b0;
         csu_ff <= '0; civ_ff <= '0; ch_ff <= '0; ms_ff <= '0; pv_ff <= 1'b0;
         pc_ff <= '0; ov_ff <= 1'b0;
      end else begin
         ov_ff <= (proc && emit) || (ov_ff && !rsp_ready);
         if (proc) begin
            dol_ff <= dol_in; star_ff <= star_in; frz_ff <= frz_in; ds_ff <= ds_in;
            hs_ff <= hs_in; tm_ff <= tm_in; pf_ff <= pf_in; xs_ff <= xs_in;
            rs_ff <= rs_in; fi_ff <= fi_in; ci_ff <= ci_in; hf_ff <= hf_in;
            pt_ff <= pt_in; pd_ff <= pd_in; pfx_ff <= pfx_in; psu_ff <= psu_in;
            piv_ff <= piv_in; ph_ff <= ph_in; ct_ff <= ct_in; cd_ff <= cd_in;
            cfx_ff <= cfx_in; csu_ff <= csu_in; civ_ff <= civ_in; ch_ff <= ch_in;
            ms_ff <= ms_in; pv_ff <= pv_in; pc_ff <= pc_in;
         end
      end
      if (proc && emit) begin
         out_ff.event_res <= ev;
         out_ff.has_fix <= cfx_in;
         out_ff.utc_time_bcd <= ct_in;
         out_ff.date_bcd <= cd_in;
         out_ff.sats_used <= csu_in;
         out_ff.hdop_centi <= ch_in;
         out_ff.sats_visible <= civ_in;
         out_ff.pulse_valid <= pv_in;
         out_ff.pulse_count <= pc_in;
      end
   end
endmodule

/* rtl/nmea_sentence_parser_top.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_parser_top
// NMEA sentence parser with pulse-per-second supervision.
// ----------------------------------------------------------------------------
// Takes one item per cycle: a front stage sorts each item into at most one
// action queued in a two-entry buffer, and the back stage executes one
// action per cycle into a result register, so throughput is one item per
// clock while results are taken. A line feed, a pulse edge or a pulse
// timeout produces one result transfer; other items produce none.
`include "nmea_sentence_parser_top_assert.svh"
module nmea_sentence_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nsp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nsp_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   logic [15:0] timeout_ff;
   logic op_valid, op_ready;
   nsp_pkg::op_type op_data;

   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= nsp_pkg::TIMEOUT_RESET;
      else if (csr_we) timeout_ff <= csr_wdata;
   end

   nsp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .op_valid, .op_ready, .op_data
   );

   nsp_back u_back (
      .clock, .reset, .timeout(timeout_ff), .op_valid, .op_ready, .op_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   `NSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `NSP_ASSERT_IMPL(a_ev_range, clock, reset, rsp_valid |-> rsp_data.event_res <= nsp_pkg::EV_TIMEOUT)
   `NSP_ASSERT_NEXT(a_pulse_cnt, clock, reset, op_valid && op_ready && op_data.is_pulse, rsp_valid && rsp_data.pulse_valid)
endmodule
